/* src/rtu_pkg.sv */
// Shared types and codes for the route table update block.
// No dependencies; imported by rtu_cell and route_table_update.
package rtu_pkg;

  localparam int NET_W     = 32;
  localparam int HOP_W     = 8;
  localparam int OUTCOME_W = 2;
  localparam int SLOT_W    = 4;
  localparam int TOTAL_W   = 5;

  localparam logic [OUTCOME_W-1:0] OUT_KEPT     = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_UPDATED  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_INSERTED = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUT_DROPPED  = 2'd3;

  // Lookup token that walks down the cell chain, one cell per cycle.
  typedef struct packed {
    logic                 valid;
    logic                 done;
    logic [OUTCOME_W-1:0] outcome;
    logic [NET_W-1:0]     network;
    logic [NET_W-1:0]     gateway;
    logic [HOP_W-1:0]     hops;
  } token_t;

endpackage

/* src/rtu_cell.sv */
// One route slot of the chain: holds one entry and checks the passing token.
// Depends on rtu_pkg.
module rtu_cell #(
  parameter int SLOTS = 16,
  parameter int IDX   = 0
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [$clog2(SLOTS+1)-1:0]            count,
  input  rtu_pkg::token_t                       tok_in,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] slot_in,
  output rtu_pkg::token_t                       tok_out,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] slot_out
);
  import rtu_pkg::*;

  localparam int CW = $clog2(SLOTS + 1);
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [CW-1:0] MY_COUNT = CW'(IDX);
  localparam logic [SW-1:0] MY_SLOT  = SW'(IDX);

  logic [NET_W-1:0] network;
  logic [NET_W-1:0] gateway;
  logic [HOP_W-1:0] hops;

  logic             live;
  logic             match;
  logic             shorter;
  logic             insert;
  token_t           tok_next;
  logic [SW-1:0]    slot_next;

  assign live    = tok_in.valid && !tok_in.done;
  assign match   = live && (count > MY_COUNT) && (network == tok_in.network);
  assign shorter = tok_in.hops < hops;
  assign insert  = live && (count == MY_COUNT);

  always_comb begin
    tok_next  = tok_in;
    slot_next = slot_in;
    if (match) begin
      tok_next.done    = 1'b1;
      tok_next.outcome = shorter ? OUT_UPDATED : OUT_KEPT;
      slot_next        = MY_SLOT;
    end else if (insert) begin
      tok_next.done    = 1'b1;
      tok_next.outcome = OUT_INSERTED;
      slot_next        = MY_SLOT;
    end
  end

  // Entry storage: write on insert, or on a match with a shorter route.
  always_ff @(posedge clk) begin
    if (insert) begin
      network <= tok_in.network;
      gateway <= tok_in.gateway;
      hops    <= tok_in.hops;
    end else if (match && shorter) begin
      gateway <= tok_in.gateway;
      hops    <= tok_in.hops;
    end
  end

  // Hand the token to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
    slot_out <= slot_next;
  end

endmodule

/* src/route_table_update.sv */
// Top level of the route table update block: a chain of route slot cells.
// Depends on rtu_pkg and rtu_cell.
//
//  channel  | ports                                      | handshake
//  ---------+--------------------------------------------+--------------------------
//  command  | network_id, next_hop_id, hop_count         | start high, busy low
//  result   | outcome, slot_index, entry_total           | done high for one cycle
//
// An accepted advertisement walks the chain one cell per cycle; done rises
// once the token has left the last cell, and busy drops at that same edge,
// so a new advertisement is taken only after the previous one is through.
// The chain length, ROUTE_SLOTS, sets how long that takes. Reset (rst,
// synchronous) empties the table by clearing the entry count. The receiver
// cannot stall: each result is shown for exactly one cycle.
module route_table_update #(
  parameter int ROUTE_SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [rtu_pkg::NET_W-1:0]       network_id,
  input  logic [rtu_pkg::NET_W-1:0]       next_hop_id,
  input  logic [rtu_pkg::HOP_W-1:0]       hop_count,
  output logic                            done,
  output logic [rtu_pkg::OUTCOME_W-1:0]   outcome,
  output logic [rtu_pkg::SLOT_W-1:0]      slot_index,
  output logic [rtu_pkg::TOTAL_W-1:0]     entry_total
);
  import rtu_pkg::*;

  localparam int CW = $clog2(ROUTE_SLOTS + 1);
  localparam int SW = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  token_t        head;
  token_t        tok  [ROUTE_SLOTS+1];
  logic [SW-1:0] slot [ROUTE_SLOTS+1];
  token_t        tail;
  logic [SW-1:0] tail_slot;
  logic          accept;

  assign accept = start && !busy;

  always_comb begin
    head.valid    = accept;
    head.done     = 1'b0;
    head.outcome  = OUT_KEPT;
    head.network  = network_id;
    head.gateway  = next_hop_id;
    head.hops     = hop_count;
  end

  assign tok[0]  = head;
  assign slot[0] = '0;

  for (genvar i = 0; i < ROUTE_SLOTS; i++) begin : g_cell
    rtu_cell #(
      .SLOTS (ROUTE_SLOTS),
      .IDX   (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .count    (count),
      .tok_in   (tok[i]),
      .slot_in  (slot[i]),
      .tok_out  (tok[i+1]),
      .slot_out (slot[i+1])
    );
  end

  assign tail      = tok[ROUTE_SLOTS];
  assign tail_slot = slot[ROUTE_SLOTS];

  assign count_next = (tail.done && tail.outcome == OUT_INSERTED) ? count + CW'(1) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (tail.valid) begin
        busy <= 1'b0;
      end
      done <= tail.valid;
      if (tail.valid) begin
        count <= count_next;
      end
    end
  end

  // Result beat; a token that found no slot is a drop.
  always_ff @(posedge clk) begin
    if (tail.valid) begin
      outcome     <= tail.done ? tail.outcome : OUT_DROPPED;
      slot_index  <= tail.done ? SLOT_W'(tail_slot) : '0;
      entry_total <= TOTAL_W'(count_next);
    end
  end

endmodule
